// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console writer: cell layout, control
// byte codes, item actions and register map.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // one screen cell, attribute in the high byte
  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
  } cell_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_req_t;

  localparam logic [7:0] LF_CODE  = 8'd10;
  localparam logic [7:0] CR_CODE  = 8'd13;
  localparam logic [7:0] TAB_CODE = 8'd9;

  localparam int unsigned TAB_STOP  = 8;
  localparam int unsigned RESET_ROW = 17;

  localparam cell_t BLANK_CELL = '{attr: 8'h07, chr: 8'h00};

  localparam logic [7:0] RESET_ATTR = 8'h0E;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // register word index, taken from paddr[2]
  localparam logic REG_CHAR_ATTR = 1'b0;

endpackage

// ===== sv/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console: a ROWS x COLUMNS cell buffer with a cursor,
// put and read items, scroll by row rotation.
// ----------------------------------------------------------------------------
// One item is handled at a time. A put of a printable byte, line feed,
// carriage return or tab goes from acceptance through the execute and
// finish states into the result register; a read takes the same path, its
// cell coming from the registered memory read. Everything goes through one
// shared address unit and a single-port cell memory, one access a cycle.
// A scroll does not move any cells: the row base advances and the new
// bottom row is blanked, one cell a cycle, before the put finishes. After
// reset the block clears the whole buffer one cell a cycle, with in_ready
// low; configuration writes are taken throughout. A finished result sits
// in the output register, so the next item is taken while it waits; a
// further result stalls until the first is taken.
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [CW:0]   COLS_X   = (CW+1)'(COLUMNS);
  localparam logic [CW:0]   TAB_MASK = (CW+1)'(tcw_pkg::TAB_STOP - 1);
  localparam logic [RW:0]   ROWS_Y   = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] BASE_MAX = RW'(ROWS - 1);
  localparam logic [RW-1:0] HOME_ROW =
    (tcw_pkg::RESET_ROW < ROWS - 1) ? RW'(tcw_pkg::RESET_ROW) : RW'(ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_BLANK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // item held for execution
  logic        item_action_r;
  logic [7:0]  item_code_r;
  logic [4:0]  item_row_r;
  logic [6:0]  item_col_r;

  logic [CW-1:0] cursor_x_r, cursor_x_nxt;
  logic [RW-1:0] cursor_y_r, cursor_y_nxt;
  logic [RW-1:0] base_r, base_nxt;
  logic [RW-1:0] sweep_row_r, sweep_row_nxt;
  logic [CW-1:0] sweep_col_r, sweep_col_nxt;
  logic          hit_r, hit_nxt;
  logic [7:0]    char_attr_r;

  logic        out_valid_r;
  logic [6:0]  out_cursor_col_r;
  logic [4:0]  out_cursor_row_r;
  logic [7:0]  out_cell_char_r;
  logic [7:0]  out_cell_attr_r;

  // shared address unit and memory hookup
  logic [RW-1:0]      au_row;
  logic [CW-1:0]      au_col;
  logic [AW-1:0]      mem_addr;
  tcw_pkg::mem_req_t  mem_req;
  tcw_pkg::cell_t     mem_wr_cell;
  tcw_pkg::cell_t     mem_rd_cell;

  // cursor arithmetic for a put
  logic [CW:0] x_ext;
  logic [CW:0] x_step;
  logic [RW:0] y_next;
  logic        new_line;
  logic        read_hit;
  logic        sweep_last;
  logic        out_free;
  logic        cfg_wr;

  assign in_ready   = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_ready;
  assign sweep_last = (sweep_row_r == LAST_ROW) && (sweep_col_r == LAST_COL);
  assign read_hit   = (32'(item_row_r) < ROWS) && (32'(item_col_r) < COLUMNS);

  assign x_ext  = {1'b0, cursor_x_r};
  // tab rounds up to the next stop, any printable byte moves one on
  assign x_step = (item_code_r == tcw_pkg::TAB_CODE) ? ((x_ext | TAB_MASK) + 1'b1)
                                                      : (x_ext + 1'b1);
  assign new_line = (item_code_r == tcw_pkg::LF_CODE) || (x_step >= COLS_X);
  assign y_next   = {1'b0, cursor_y_r} + 1'b1;

  // address source: cursor or read position while executing, sweep otherwise
  always_comb begin
    au_row = sweep_row_r;
    au_col = sweep_col_r;
    if (state_r == S_EXEC) begin
      if (item_action_r == tcw_pkg::ACT_PUT) begin
        au_row = cursor_y_r;
        au_col = cursor_x_r;
      end else begin
        au_row = RW'(item_row_r);
        au_col = CW'(item_col_r);
      end
    end
  end

  tcw_addr_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CW      (CW),
    .RW      (RW),
    .AW      (AW)
  ) u_addr (
    .row  (au_row),
    .col  (au_col),
    .base (base_r),
    .addr (mem_addr)
  );

  tcw_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .req     (mem_req),
    .addr    (mem_addr),
    .wr_cell (mem_wr_cell),
    .rd_cell (mem_rd_cell)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    base_nxt      = base_r;
    sweep_row_nxt = sweep_row_r;
    sweep_col_nxt = sweep_col_r;
    hit_nxt       = hit_r;
    mem_req       = '0;
    mem_wr_cell   = tcw_pkg::BLANK_CELL;

    case (state_r)
      S_CLEAR, S_BLANK: begin
        mem_req.wr_en = 1'b1;
        if (sweep_col_r == LAST_COL) begin
          sweep_col_nxt = '0;
          sweep_row_nxt = sweep_row_r + 1'b1;
        end else begin
          sweep_col_nxt = sweep_col_r + 1'b1;
        end
        if (sweep_last) begin
          state_nxt = (state_r == S_CLEAR) ? S_IDLE : S_FINISH;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_FINISH;
        hit_nxt   = 1'b0;
        if (item_action_r == tcw_pkg::ACT_READ) begin
          hit_nxt       = read_hit;
          mem_req.rd_en = read_hit;
        end else begin
          case (item_code_r)
            tcw_pkg::CR_CODE: begin
              cursor_x_nxt = '0;
            end
            tcw_pkg::LF_CODE, tcw_pkg::TAB_CODE: begin
              cursor_x_nxt = new_line ? '0 : CW'(x_step);
            end
            default: begin
              // printable byte lands at the cursor before any scroll
              mem_req.wr_en = 1'b1;
              mem_wr_cell   = '{attr: char_attr_r, chr: item_code_r};
              cursor_x_nxt  = new_line ? '0 : CW'(x_step);
            end
          endcase
          if (new_line && item_code_r != tcw_pkg::CR_CODE) begin
            if (y_next == ROWS_Y) begin
              // scroll: rotate the base, blank the new bottom row
              cursor_y_nxt  = LAST_ROW;
              base_nxt      = (base_r == BASE_MAX) ? '0 : base_r + 1'b1;
              sweep_row_nxt = LAST_ROW;
              sweep_col_nxt = '0;
              state_nxt     = S_BLANK;
            end else begin
              cursor_y_nxt = RW'(y_next);
            end
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cursor_x_r  <= '0;
      cursor_y_r  <= HOME_ROW;
      base_r      <= '0;
      sweep_row_r <= '0;
      sweep_col_r <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      base_r      <= base_nxt;
      sweep_row_r <= sweep_row_nxt;
      sweep_col_r <= sweep_col_nxt;
      hit_r       <= hit_nxt;
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_action_r <= in_action;
      item_code_r   <= in_char_code;
      item_row_r    <= in_read_row;
      item_col_r    <= in_read_col;
    end
    if (state_r == S_FINISH && out_free) begin
      out_cursor_col_r <= 7'(cursor_x_r);
      out_cursor_row_r <= 5'(cursor_y_r);
      out_cell_char_r  <= hit_r ? mem_rd_cell.chr  : 8'h00;
      out_cell_attr_r  <= hit_r ? mem_rd_cell.attr : 8'h00;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_cursor_col_r;
  assign out_cursor_row = out_cursor_row_r;
  assign out_cell_char  = out_cell_char_r;
  assign out_cell_attr  = out_cell_attr_r;

  // configuration port, one register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_attr_r <= tcw_pkg::RESET_ATTR;
    end else if (cfg_wr && cfg_paddr[2] == tcw_pkg::REG_CHAR_ATTR) begin
      char_attr_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == tcw_pkg::REG_CHAR_ATTR) ? {24'h0, char_attr_r}
                                                               : 32'h0;

  // checks
  a_cursor_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cursor_y_r) < ROWS)
    else $error("cursor row beyond last row");

  a_cursor_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cursor_x_r) < COLUMNS)
    else $error("cursor column beyond last column");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(base_r) < ROWS)
    else $error("row base out of range");

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("memory read and write in one cycle");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

endmodule

// ===== sv/tcw_addr_unit.sv =====
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared address unit: maps a logical row and column onto the cell memory,
// rotating the row by the scroll base.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int CW      = 7,
  parameter int RW      = 5,
  parameter int AW      = 11
) (
  input  logic [RW-1:0] row,
  input  logic [CW-1:0] col,
  input  logic [RW-1:0] base,
  output logic [AW-1:0] addr
);

  localparam logic [RW:0]   ROWS_E = (RW+1)'(ROWS);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  logic [RW:0]   row_sum;
  logic [RW:0]   phys_row;

  // logical row plus base, wrapped once
  assign row_sum  = {1'b0, row} + {1'b0, base};
  assign phys_row = (row_sum >= ROWS_E) ? (row_sum - ROWS_E) : row_sum;
  assign addr     = AW'(phys_row) * COLS_A + AW'(col);

endmodule

// ===== sv/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Single-port cell memory with registered read data; read data holds until
// the next read.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  tcw_pkg::mem_req_t req,
  input  logic [AW-1:0]    addr,
  input  tcw_pkg::cell_t   wr_cell,
  output tcw_pkg::cell_t   rd_cell
);

  tcw_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= wr_cell;
    end
    if (req.rd_en) begin
      rd_cell <= mem[addr];
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer core. A mirror of the
// screen buffer and cursor predicts every reply; puts, control bytes, tabs,
// wraps, scrolls and cell reads are driven with random gaps and stalls on
// both channels, across several char_attr settings.
// ----------------------------------------------------------------------------

localparam int SCREEN_COLS = 80;
localparam int SCREEN_ROWS = 25;

typedef struct {
  logic       action;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;
} console_item_t;

typedef struct {
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
} console_reply_t;

// mirror of the console state plus the replies still awaited
class console_mirror;
  tcw_pkg::cell_t screen [SCREEN_COLS*SCREEN_ROWS];
  int unsigned    cur_col;
  int unsigned    cur_row;
  logic [7:0]     char_attr;
  console_reply_t predicted_replies [$];
  int             errors;

  function new();
    int i;
    errors = 0;
    for (i = 0; i < SCREEN_COLS*SCREEN_ROWS; i++) screen[i] = tcw_pkg::BLANK_CELL;
    cur_col = 0;
    cur_row = (tcw_pkg::RESET_ROW < SCREEN_ROWS - 1) ? tcw_pkg::RESET_ROW : SCREEN_ROWS - 1;
    char_attr = tcw_pkg::RESET_ATTR;
  endfunction

  function void set_attr(logic [7:0] a);
    char_attr = a;
  endfunction

  function int outstanding();
    return predicted_replies.size();
  endfunction

  function void new_line();
    cur_col = 0;
    cur_row++;
  endfunction

  // advance the mirror by one accepted item and queue the reply it causes
  function void note_item(console_item_t it);
    console_reply_t r;
    int             i;
    r = '{default: '0};
    if (it.action == tcw_pkg::ACT_PUT) begin
      if (it.char_code == tcw_pkg::LF_CODE) begin
        new_line();
      end else if (it.char_code == tcw_pkg::TAB_CODE) begin
        cur_col = cur_col + tcw_pkg::TAB_STOP - (cur_col % tcw_pkg::TAB_STOP);
        if (cur_col >= SCREEN_COLS) new_line();
      end else if (it.char_code == tcw_pkg::CR_CODE) begin
        cur_col = 0;
      end else begin
        screen[cur_row*SCREEN_COLS + cur_col] = '{attr: char_attr, chr: it.char_code};
        cur_col++;
        if (cur_col >= SCREEN_COLS) new_line();
      end
      // scroll up one line, bottom row blank
      if (cur_row > SCREEN_ROWS - 1) begin
        for (i = 0; i < SCREEN_COLS*(SCREEN_ROWS - 1); i++) screen[i] = screen[i + SCREEN_COLS];
        for (i = 0; i < SCREEN_COLS; i++)
          screen[SCREEN_COLS*(SCREEN_ROWS - 1) + i] = tcw_pkg::BLANK_CELL;
        cur_row = SCREEN_ROWS - 1;
      end
    end else if (it.read_row < SCREEN_ROWS && it.read_col < SCREEN_COLS) begin
      r.cell_char = screen[it.read_row*SCREEN_COLS + it.read_col].chr;
      r.cell_attr = screen[it.read_row*SCREEN_COLS + it.read_col].attr;
    end
    r.cursor_col = cur_col[6:0];
    r.cursor_row = cur_row[4:0];
    predicted_replies.push_back(r);
  endfunction

  function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
    if (act !== exp) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
    end
  endfunction

  function void check_reply(console_reply_t got);
    console_reply_t exp;
    if (predicted_replies.size() == 0) begin
      errors++;
      $display("%0t: reply with no item pending, actual col %0d row %0d char %0d attr %0d",
               $time, got.cursor_col, got.cursor_row, got.cell_char, got.cell_attr);
    end else begin
      exp = predicted_replies.pop_front();
      compare_field("cursor_col", {1'b0, exp.cursor_col}, {1'b0, got.cursor_col});
      compare_field("cursor_row", {3'b0, exp.cursor_row}, {3'b0, got.cursor_row});
      compare_field("cell_char", exp.cell_char, got.cell_char);
      compare_field("cell_attr", exp.cell_attr, got.cell_attr);
    end
  endfunction
endclass

module tb_top;

  // reset clear pass, scrolls and stalls all fit well inside this
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASE_ITEMS     = 330;
  localparam int LONG_HOLD       = 300;
  localparam logic [2:0] CHAR_ATTR_ADDR = {tcw_pkg::REG_CHAR_ATTR, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = tcw_pkg::ACT_PUT;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_read_row = '0;
  logic [6:0]  in_read_col = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_cursor_col;
  logic [4:0]  out_cursor_row;
  logic [7:0]  out_cell_char;
  logic [7:0]  out_cell_attr;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  console_mirror mirror;

  // idling switch and the one long receiver hold-off
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int reg_read_errors = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  text_console_writer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  function automatic console_item_t make_item(logic act, logic [7:0] code,
                                              logic [4:0] row, logic [6:0] col);
    console_item_t it;
    it.action    = act;
    it.char_code = code;
    it.read_row  = row;
    it.read_col  = col;
    return it;
  endfunction

  // mostly puts, weighted towards control bytes, plus reads that often
  // land just behind the cursor so fresh writes are seen straight away
  function automatic console_item_t random_item();
    int          pick;
    int          sub;
    logic [4:0]  row;
    logic [6:0]  col;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 9);
    code = 8'($urandom_range(0, 255));
    row  = 5'($urandom_range(0, 31));
    col  = 7'($urandom_range(0, 127));
    if (pick < 30) begin
      if (sub >= 2 && sub <= 4) begin
        row = mirror.cur_row[4:0];
        col = (mirror.cur_col > 0) ? 7'(mirror.cur_col - 1) : 7'd0;
      end else if (sub >= 5) begin
        row = 5'($urandom_range(0, SCREEN_ROWS - 1));
        col = 7'($urandom_range(0, SCREEN_COLS - 1));
      end
      return make_item(tcw_pkg::ACT_READ, code, row, col);
    end
    if (pick < 36) code = tcw_pkg::LF_CODE;
    else if (pick < 40) code = tcw_pkg::CR_CODE;
    else if (pick < 46) code = tcw_pkg::TAB_CODE;
    return make_item(tcw_pkg::ACT_PUT, code, row, col);
  endfunction

  // offer one item, optionally after a gap, and hold it until taken
  task automatic send_item(console_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= it.action;
    in_char_code <= it.char_code;
    in_read_row  <= it.read_row;
    in_read_col  <= it.read_col;
    do @(posedge clk); while (in_ready !== 1'b1);
    mirror.note_item(it);
  endtask

  // stop offering and wait until every reply is back
  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // read back the attribute register and compare its byte
  task automatic apb_read_check(logic [2:0] addr, logic [7:0] exp);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata[7:0] !== exp) begin
      reg_read_errors++;
      $display("%0t: char_attr readback mismatch, expected %0d, actual %0d",
               $time, exp, cfg_prdata[7:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result side: random stall bursts, one long hold-off, checks every reply
  initial begin
    int stall_left;
    int hold_left;
    console_reply_t got;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.cursor_col = out_cursor_col;
        got.cursor_row = out_cursor_row;
        got.cell_char  = out_cell_char;
        got.cell_attr  = out_cell_attr;
        mirror.check_reply(got);
      end
      if (long_hold_req && !long_hold_done) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          phase;
    logic [7:0]  attr_val;
    logic [31:0] wdata;
    mirror = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // register reset value, taken during the clear pass
    apb_read_check(CHAR_ATTR_ADDR, mirror.char_attr);

    // directed: reads of blank and off-screen cells
    send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 5'd0, 7'd0));
    send_item(make_item(tcw_pkg::ACT_READ, 8'hFF, 5'd31, 7'd127));
    send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 5'd24, 7'd80));
    send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 5'd25, 7'd79));
    // printable bytes, byte 0 included, with junk in the read fields
    send_item(make_item(tcw_pkg::ACT_PUT, 8'h41, 5'd31, 7'd127));
    send_item(make_item(tcw_pkg::ACT_PUT, 8'h00, 5'd0, 7'd0));
    send_item(make_item(tcw_pkg::ACT_PUT, 8'hFF, 5'd24, 7'd79));
    send_item(make_item(tcw_pkg::ACT_PUT, tcw_pkg::CR_CODE, 5'd0, 7'd0));
    // read back what was printed, char_code ignored on reads
    send_item(make_item(tcw_pkg::ACT_READ, 8'hFF, 5'd17, 7'd0));
    send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 5'd17, 7'd2));
    // tabs to the last stop, then a tab past the last column wraps
    repeat (10) send_item(make_item(tcw_pkg::ACT_PUT, tcw_pkg::TAB_CODE, 5'd0, 7'd0));
    // line feeds down to the bottom and one scroll
    repeat (7) send_item(make_item(tcw_pkg::ACT_PUT, tcw_pkg::LF_CODE, 5'd0, 7'd0));
    send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 5'd16, 7'd0));
    send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 5'd24, 7'd0));
    drain();

    // random phases, one attribute setting each; the last has no idling
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       attr_val = 8'hFF;
        1:       attr_val = 8'h00;
        default: attr_val = 8'($urandom_range(0, 255));
      endcase
      if (phase == 5) idle_on = 1'b0;
      wdata       = $urandom();
      wdata[7:0]  = attr_val;
      apb_write(CHAR_ATTR_ADDR, wdata);
      mirror.set_attr(attr_val);
      apb_read_check(CHAR_ATTR_ADDR, attr_val);
      if (phase == 0) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_item(random_item());
      drain();
    end

    repeat (20) @(posedge clk);
    if (mirror.errors == 0 && reg_read_errors == 0 && mirror.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcw_pkg.sv
sv/tcw_addr_unit.sv
sv/tcw_cell_ram.sv
sv/text_console_writer_core.sv
verif/tb_top.sv
